@@ hdl/bcpe_pkg.sv @@
// ============================================================================
// bcpe_pkg: shared constants and types for the Bezier curve point evaluator
// Holds the curve size limits, fixed-point widths and the control bundle
// that the sequencer passes to each coordinate lane.
// ============================================================================
package bcpe_pkg;

    // Largest number of control points the block can hold.
    localparam int MAX_POINTS = 8;
    // Samples per curve, a power of two; t = k / SAMPLES.
    localparam int SAMPLES    = 1024;

    // Fractional bits of t and of every interpolated value.
    localparam int FRAC_W     = 16;
    // t ranges over 0 .. 1.0, so it needs one integer bit.
    localparam int T_W        = FRAC_W + 1;
    // Left shift that turns a sample index into t.
    localparam int T_SHIFT    = FRAC_W - $clog2(SAMPLES);

    // Field widths of the streams.
    localparam int COORD_W    = 16;
    localparam int VAL_W      = 32;
    localparam int SAMPLE_W   = 10;
    localparam int PIDX_W     = 3;
    localparam int CFG_W      = 4;

    // Store addressing and point count widths.
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Command codes carried in s_tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Control bundle from the sequencer to a coordinate lane.
    typedef struct packed {
        logic             store_we;  // write one control point
        logic [IDX_W-1:0] store_idx; // control point written
        logic             start;     // copy control points into the work row
        logic             step;      // run one interpolation
        logic             last;      // last interpolation of this round
        logic [IDX_W-1:0] wr_pos;    // work row slot that takes the result
    } ctrl_t;

endpackage

@@ hdl/bezier_curve_point_evaluator.sv @@
// ============================================================================
// bezier_curve_point_evaluator: de Casteljau Bezier curve point evaluator
// Stores up to MAX_POINTS integer control points and evaluates the curve
// at t = k / SAMPLES, giving x and y in signed Q16.16.
// ============================================================================
// Usage:
//   Input stream (s_*): s_tuser selects the transaction kind. A load writes
//   one control point and produces nothing; an evaluate produces one curve
//   point on the output stream (m_*), echoing its sample index.
//   Configuration (cfg_*): num_control, the number of control points in use
//   (0 counts as 1, values above MAX_POINTS as MAX_POINTS). Always ready.
//   Timing: a load is written while the block stays idle. An evaluate runs
//   the interpolation rounds of the sequencer, then its done state loads the
//   output register; s_tready returns high in the same cycle that m_tvalid
//   rises with the result. The rounds run one lerp a cycle on the single
//   multiplier of each coordinate lane.
//   The block takes one transaction at a time; s_tready is low while an
//   evaluation runs.
//   Stalls: the result sits in an output register. The block accepts new
//   transactions while it waits; a following evaluate holds in its final
//   cycle until the output register frees up.
//   Reset: aresetn clears the sequencer and output valid and sets
//   num_control to 4. Control points are undefined until loaded.
// ============================================================================
module bezier_curve_point_evaluator (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcpe_pkg::CFG_W-1:0]    cfg_data,   // num_control
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,    // point_index[2:0],
                                                      // point_x[18:3],
                                                      // point_y[34:19],
                                                      // sample_index[44:35]
    input  logic                          s_tuser,    // cmd
    // Output stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [79:0]                   m_tdata     // curve_x[31:0],
                                                      // curve_y[63:32],
                                                      // sample_echo[73:64]
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int CNT_W = bcpe_pkg::CNT_W;
    localparam int IDX_W = bcpe_pkg::IDX_W;

    logic [1:0]                     state_reg, state_next;
    logic [bcpe_pkg::CFG_W-1:0]     num_control_reg;
    logic [CNT_W-1:0]               len_reg, len_next;
    logic [CNT_W-1:0]               step_reg, step_next;
    logic [bcpe_pkg::T_W-1:0]       t_reg;
    logic [bcpe_pkg::SAMPLE_W-1:0]  sample_reg;
    logic                           m_valid_reg;
    logic [79:0]                    m_data_reg;

    logic                           in_fire;
    logic                           eval_fire;
    logic                           round_last;
    logic                           out_load;
    logic [CNT_W-1:0]               n_eff;
    logic [bcpe_pkg::T_W-1:0]       t_next;
    bcpe_pkg::ctrl_t                ctrl;

    logic [bcpe_pkg::PIDX_W-1:0]          in_pidx;
    logic signed [bcpe_pkg::COORD_W-1:0]  in_px;
    logic signed [bcpe_pkg::COORD_W-1:0]  in_py;
    logic [bcpe_pkg::SAMPLE_W-1:0]        in_sample;
    logic signed [bcpe_pkg::VAL_W-1:0]    res_x;
    logic signed [bcpe_pkg::VAL_W-1:0]    res_y;

    // Unpack the input transaction.
    assign in_pidx   = s_tdata[2:0];
    assign in_px     = s_tdata[18:3];
    assign in_py     = s_tdata[34:19];
    assign in_sample = s_tdata[44:35];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign eval_fire = in_fire && (s_tuser == bcpe_pkg::CMD_EVAL);
    assign cfg_ready = 1'b1;

    // Effective point count, clamped to 1 .. MAX_POINTS.
    always_comb begin
        if (num_control_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (int'(num_control_reg) > bcpe_pkg::MAX_POINTS) begin
            n_eff = CNT_W'(bcpe_pkg::MAX_POINTS);
        end else begin
            n_eff = CNT_W'(num_control_reg);
        end
    end

    // Curve parameter t in Q1.16, saturated to 1.0 past the last sample.
    always_comb begin
        if (bcpe_pkg::T_W'(in_sample) >= bcpe_pkg::T_W'(bcpe_pkg::SAMPLES)) begin
            t_next = bcpe_pkg::T_W'(1) << bcpe_pkg::FRAC_W;
        end else begin
            t_next = bcpe_pkg::T_W'(in_sample) << bcpe_pkg::T_SHIFT;
        end
    end

    // Round bookkeeping: a round of length L runs L-1 interpolations.
    assign round_last = (step_reg == len_reg - CNT_W'(2));
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // Lane control bundle.
    always_comb begin
        ctrl.store_we  = in_fire && (s_tuser == bcpe_pkg::CMD_LOAD)
                      && (int'(in_pidx) < bcpe_pkg::MAX_POINTS);
        ctrl.store_idx = IDX_W'(in_pidx);
        ctrl.start     = eval_fire;
        ctrl.step      = (state_reg == ST_RUN);
        ctrl.last      = round_last;
        ctrl.wr_pos    = round_last ? IDX_W'(len_reg - CNT_W'(2))
                                    : IDX_W'(len_reg - CNT_W'(1));
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (eval_fire) begin
                    len_next   = n_eff;
                    step_next  = '0;
                    state_next = (n_eff == CNT_W'(1)) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (round_last) begin
                    len_next  = len_reg - CNT_W'(1);
                    step_next = '0;
                    if (len_reg == CNT_W'(2)) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    step_next = step_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            num_control_reg <= bcpe_pkg::CFG_W'(4);
            m_valid_reg     <= 1'b0;
            len_reg         <= '0;
            step_reg        <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            step_reg  <= step_next;
            if (cfg_valid && cfg_ready) begin
                num_control_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Evaluation operands and the output register.
    always_ff @(posedge aclk) begin
        if (eval_fire) begin
            t_reg      <= t_next;
            sample_reg <= in_sample;
        end
        if (out_load) begin
            m_data_reg <= {6'b0, sample_reg, res_y, res_x};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Coordinate lanes.
    bcpe_lane u_lane_x (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .point  (in_px),
        .t_val  (t_reg),
        .result (res_x)
    );

    bcpe_lane u_lane_y (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .point  (in_py),
        .t_val  (t_reg),
        .result (res_y)
    );

    // While interpolating, the round holds at least two values and the
    // step counter stays inside the round.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (len_reg >= CNT_W'(2)) && (step_reg <= len_reg - CNT_W'(2)))
        else $error("interpolation round counters out of range");

    // A new result appears only after the final state of an evaluation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("output loaded outside the done state");

    // An accepted evaluate leaves the idle state on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        eval_fire |=> (state_reg == ST_RUN) || (state_reg == ST_DONE))
        else $error("evaluate did not start the sequencer");

    // Loads never start an evaluation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.store_we |-> !ctrl.start)
        else $error("load and evaluate issued together");

endmodule

@@ hdl/bcpe_lane.sv @@
// ============================================================================
// bcpe_lane: one coordinate lane of the de Casteljau evaluator
// Holds the control points of one coordinate and a work row, and runs one
// interpolation a cycle on its own multiplier under the sequencer's control.
// ============================================================================
module bcpe_lane (
    input  logic                                aclk,
    input  bcpe_pkg::ctrl_t                     ctrl,
    input  logic signed [bcpe_pkg::COORD_W-1:0] point,
    input  logic        [bcpe_pkg::T_W-1:0]     t_val,
    output logic signed [bcpe_pkg::VAL_W-1:0]   result
);

    localparam int M = bcpe_pkg::MAX_POINTS;

    logic signed [bcpe_pkg::COORD_W-1:0] store_reg [M];
    logic signed [bcpe_pkg::VAL_W-1:0]   work_reg  [M];
    logic signed [bcpe_pkg::VAL_W-1:0]   work_next [M];

    logic signed [bcpe_pkg::VAL_W:0]               diff;
    logic signed [bcpe_pkg::VAL_W+bcpe_pkg::T_W:0] prod;
    logic signed [bcpe_pkg::VAL_W:0]               delta;
    logic signed [bcpe_pkg::VAL_W:0]               sum;
    logic signed [bcpe_pkg::VAL_W-1:0]             lerp;

    // Control point store; its contents are undefined until written.
    always_ff @(posedge aclk) begin
        if (ctrl.store_we) begin
            store_reg[ctrl.store_idx] <= point;
        end
    end

    // Shared interpolation unit: a + floor((b - a) * t / 2^16).
    always_comb begin
        diff  = {work_reg[1][bcpe_pkg::VAL_W-1], work_reg[1]}
              - {work_reg[0][bcpe_pkg::VAL_W-1], work_reg[0]};
        prod  = diff * $signed({1'b0, t_val});
        delta = prod[bcpe_pkg::VAL_W+bcpe_pkg::FRAC_W:bcpe_pkg::FRAC_W];
        sum   = {work_reg[0][bcpe_pkg::VAL_W-1], work_reg[0]} + delta;
        lerp  = sum[bcpe_pkg::VAL_W-1:0];
    end

    // Work row update. Each step shifts the row down by one so the operands
    // always sit in the two lowest slots; the last step of a round shifts by
    // two to drop the final operand, and the result lands behind the others.
    always_comb begin
        int src1;
        int src2;
        src1 = 0;
        src2 = 0;
        for (int j = 0; j < M; j++) begin
            work_next[j] = work_reg[j];
        end
        if (ctrl.start) begin
            for (int j = 0; j < M; j++) begin
                work_next[j] = {store_reg[j], {bcpe_pkg::FRAC_W{1'b0}}};
            end
        end else if (ctrl.step) begin
            for (int j = 0; j < M; j++) begin
                src1 = (j + 1 < M) ? j + 1 : M - 1;
                src2 = (j + 2 < M) ? j + 2 : M - 1;
                work_next[j] = ctrl.last ? work_reg[src2] : work_reg[src1];
            end
            work_next[ctrl.wr_pos] = lerp;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < M; j++) begin
            work_reg[j] <= work_next[j];
        end
    end

    assign result = work_reg[0];

endmodule
